### rtl/core/srx_pkg.sv
// Shared constants, types and CRC function for the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package srx_pkg;

    localparam int MAX_DATA = 64;
    localparam logic [8:0] MIN_TOTAL = 9'd6;
    localparam logic [8:0] MAX_TOTAL = 9'(MAX_DATA + 9);
    localparam logic [8:0] HDR_EXTRA = 9'd3;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_BAD_END = 3'd4;
    localparam logic [2:0] ST_CRC_ERR = 3'd5;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] expected_version;
        logic [7:0] end_marker;
    } srx_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] frame_byte;
        logic [8:0] byte_position;
        logic       frame_end;
        logic [2:0] frame_status;
    } srx_res_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/srx_if.sv
// Item channel interfaces: received events in, frame results out.
`timescale 1ns / 1ps
`default_nettype none

interface srx_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_value;

    modport source (output valid, output command, output rx_value, input ready);
    modport sink (input valid, input command, input rx_value, output ready);
endinterface

interface srx_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [8:0] byte_position;
    logic       frame_end;
    logic [2:0] frame_status;

    modport source (output valid, output frame_byte, output byte_position,
                    output frame_end, output frame_status, input ready);
    modport sink (input valid, input frame_byte, input byte_position,
                  input frame_end, input frame_status, output ready);
endinterface

`default_nettype wire

### rtl/core/srx_core.sv
// Frame parsing state and per-item result logic.
`timescale 1ns / 1ps
`default_nettype none

module srx_core
    import srx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       command,
    input  wire logic [7:0] rx_value,
    input  wire srx_cfg_t   cfg,
    output srx_res_t        res
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_VER = 2'd1;
    localparam logic [1:0] PH_LEN = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  total_reg, total_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic        match_reg, match_next;
    logic [7:0]  ver_reg, ver_next;

    logic        fin;
    logic [8:0]  len_total;
    logic [9:0]  pos_p3;
    logic [9:0]  pos_p2;
    logic [9:0]  total_ext;

    assign len_total = {1'b0, rx_value} + HDR_EXTRA;
    assign pos_p3 = {1'b0, pos_reg} + 10'd3;
    assign pos_p2 = {1'b0, pos_reg} + 10'd2;
    assign total_ext = {1'b0, total_reg};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        total_next = total_reg;
        crc_next = crc_reg;
        crc_hi_next = crc_hi_reg;
        match_next = match_reg;
        ver_next = ver_reg;
        fin = 1'b0;
        res = '0;

        if (command == CMD_TIMEOUT)
        begin
            res.valid = 1'b1;
            res.frame_byte = 8'h00;
            res.byte_position = pos_reg;
            res.frame_end = 1'b1;
            res.frame_status = ST_TIMEOUT;
            fin = 1'b1;
        end
        else if (phase_reg == PH_HUNT)
        begin
            if (rx_value == cfg.start_marker)
            begin
                crc_next = crc_feed(CRC_INIT, rx_value);
                pos_next = 9'd1;
                phase_next = PH_VER;
                res.valid = 1'b1;
                res.frame_byte = rx_value;
                res.byte_position = 9'd0;
            end
        end
        else
        begin
            res.valid = 1'b1;
            res.frame_byte = rx_value;
            res.byte_position = pos_reg;
            unique case (phase_reg)
                PH_VER:
                begin
                    ver_next = rx_value;
                    crc_next = crc_feed(crc_reg, rx_value);
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    crc_next = crc_feed(crc_reg, rx_value);
                    if (ver_reg != cfg.expected_version)
                    begin
                        fin = 1'b1;
                        res.frame_status = ST_BAD_VERSION;
                    end
                    else if (len_total > MAX_TOTAL || len_total < MIN_TOTAL)
                    begin
                        fin = 1'b1;
                        res.frame_status = ST_BAD_LENGTH;
                    end
                    else
                    begin
                        total_next = len_total;
                        phase_next = PH_BODY;
                    end
                end
                default:
                begin
                    priority if (pos_p3 < total_ext)
                        crc_next = crc_feed(crc_reg, rx_value);
                    else if (pos_p3 == total_ext)
                        crc_hi_next = rx_value;
                    else if (pos_p2 == total_ext)
                        match_next = ({crc_hi_reg, rx_value} == crc_reg);
                    else
                    begin
                        fin = 1'b1;
                        if (rx_value != cfg.end_marker)
                            res.frame_status = ST_BAD_END;
                        else if (!match_reg)
                            res.frame_status = ST_CRC_ERR;
                        else
                            res.frame_status = ST_OK;
                    end
                end
            endcase
            pos_next = pos_reg + 9'd1;
        end

        res.frame_end = fin;
        if (fin)
        begin
            phase_next = PH_HUNT;
            pos_next = '0;
            total_next = '0;
            crc_next = CRC_INIT;
            crc_hi_next = '0;
            match_next = 1'b0;
            ver_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg <= '0;
            total_reg <= '0;
            crc_reg <= CRC_INIT;
            crc_hi_reg <= '0;
            match_reg <= 1'b0;
            ver_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            total_reg <= total_next;
            crc_reg <= crc_next;
            crc_hi_reg <= crc_hi_next;
            match_reg <= match_next;
            ver_reg <= ver_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/serial_frame_receiver_crc16.sv
// Top level of the serial frame receiver with CRC-16 check.
//
// item channel carries one event per item: command 0 with a received byte in
// rx_value, or command 1 for an expired response deadline. result channel
// returns zero or one item per event: the echoed frame byte, its position
// (start marker is 0), and on the last item of a frame or attempt frame_end
// with a status (ok, timeout, bad version, bad length, bad end, crc error).
// Bytes before a start marker give no result.
// An accepted event passes through the input register, then the result
// register. Throughput: one item per cycle while no result is held back; the
// CRC byte update between the two registers sets the cycle time.
// The input side keeps accepting while a result waits, as long as the
// input register can move on; when result.ready stays low, one event is
// held in the input register and item.ready drops.
// Reset clears the parser to hunting and loads the marker registers with
// start 0xAA, version 1, end 0x55. The user writes registers through
// cfg_we/cfg_index/cfg_wdata while the block is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_crc16
    import srx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    srx_item_if.sink                  item,
    srx_result_if.source              result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_wdata
);

    srx_cfg_t   cfg_reg;
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    srx_res_t   out_reg;
    srx_res_t   core_res;
    logic       go;

    assign go = in_valid_reg && (!out_reg.valid || result.ready);
    assign item.ready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= 8'd170;
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.end_marker <= 8'd85;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_MARKER: cfg_reg.start_marker <= cfg_wdata;
                REG_EXP_VERSION:  cfg_reg.expected_version <= cfg_wdata;
                REG_END_MARKER:   cfg_reg.end_marker <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_cmd_reg <= item.command;
            in_byte_reg <= item.rx_value;
        end
    end

    srx_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (go),
        .command  (in_cmd_reg),
        .rx_value (in_byte_reg),
        .cfg      (cfg_reg),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (go)
            out_reg <= core_res;
        else if (result.ready)
            out_reg.valid <= 1'b0;
    end

    assign result.valid = out_reg.valid;
    assign result.frame_byte = out_reg.frame_byte;
    assign result.byte_position = out_reg.byte_position;
    assign result.frame_end = out_reg.frame_end;
    assign result.frame_status = out_reg.frame_status;

endmodule

`default_nettype wire

### verif/serial_frame_receiver_crc16_tb.sv
// Self-checking testbench for the serial frame receiver with CRC-16 check.
`timescale 1ns / 1ps

module serial_frame_receiver_crc16_tb;
    import srx_pkg::*;

    localparam int RANDOM_ROUNDS = 8;
    localparam int RESULTS_PER_ROUND = 200;
    localparam int LONG_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DIR_ROWS = 33;

    typedef enum logic [1:0] {P_HUNT, P_VERSION, P_LENGTH, P_BODY} parse_phase_t;
    typedef enum logic [1:0] {SEL_LIT, SEL_CRC_HI, SEL_CRC_LO, SEL_CRC_BAD} byte_sel_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [8:0] byte_position;
        logic       frame_end;
        logic [2:0] frame_status;
    } frame_result_t;

    typedef struct packed {
        logic          command;
        logic [7:0]    rx_value;
        byte_sel_t     sel;
        logic          typed;
        logic          has_result;
        frame_result_t want;
    } dir_row_t;

    localparam frame_result_t NO_RES = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_wdata;

    srx_item_if item_ch();
    srx_result_if result_ch();

    serial_frame_receiver_crc16 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state and its copy of the marker registers
    logic [7:0] cfg_start;
    logic [7:0] cfg_version;
    logic [7:0] cfg_end;
    parse_phase_t rx_phase;
    logic [8:0] frame_pos;
    logic [8:0] frame_len_total;
    logic [15:0] crc_acc;
    logic [7:0] crc_rx_hi;
    logic crc_ok;
    logic [7:0] version_byte;

    frame_result_t expected_results[$];
    int errors = 0;
    int items_sent = 0;
    int results_predicted = 0;
    int results_checked = 0;
    int settings_used = 1;
    int status_seen[8];
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit long_hold_req = 1'b0;
    bit long_hold_ack = 1'b0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{CMD_TIMEOUT, 8'hFF, SEL_LIT, 1'b1, 1'b1, '{8'h00, 9'd0, 1'b1, ST_TIMEOUT}},
        '{CMD_BYTE, 8'h00, SEL_LIT, 1'b1, 1'b0, NO_RES},
        '{CMD_BYTE, 8'hFF, SEL_LIT, 1'b1, 1'b0, NO_RES},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b1, 1'b1, '{8'hAA, 9'd0, 1'b0, ST_OK}},
        '{CMD_BYTE, 8'h02, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h03, SEL_LIT, 1'b1, 1'b1, '{8'h03, 9'd2, 1'b1, ST_BAD_VERSION}},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h02, SEL_LIT, 1'b1, 1'b1, '{8'h02, 9'd2, 1'b1, ST_BAD_LENGTH}},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h47, SEL_LIT, 1'b1, 1'b1, '{8'h47, 9'd2, 1'b1, ST_BAD_LENGTH}},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h03, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h00, SEL_CRC_HI, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h00, SEL_CRC_LO, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h55, SEL_LIT, 1'b1, 1'b1, '{8'h55, 9'd5, 1'b1, ST_OK}},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h03, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h00, SEL_CRC_HI, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_CRC_BAD, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h55, SEL_LIT, 1'b1, 1'b1, '{8'h55, 9'd5, 1'b1, ST_CRC_ERR}},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h03, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h00, SEL_CRC_HI, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h00, SEL_CRC_LO, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h00, SEL_LIT, 1'b1, 1'b1, '{8'h00, 9'd5, 1'b1, ST_BAD_END}},
        '{CMD_BYTE, 8'hAA, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_BYTE, 8'h01, SEL_LIT, 1'b0, 1'b0, NO_RES},
        '{CMD_TIMEOUT, 8'hAA, SEL_LIT, 1'b1, 1'b1, '{8'h00, 9'd2, 1'b1, ST_TIMEOUT}}
    };

    // MSB-first CRC-16, polynomial 0x8005
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        rx_phase = P_HUNT;
        frame_pos = '0;
        frame_len_total = '0;
        crc_acc = CRC_INIT;
        crc_rx_hi = '0;
        crc_ok = 1'b0;
        version_byte = '0;
    endfunction

    function automatic bit predict_frame_result(input logic cmd, input logic [7:0] rx,
                                                output frame_result_t r);
        logic [8:0] total;
        r = NO_RES;
        if (cmd == CMD_TIMEOUT)
        begin
            r.byte_position = frame_pos;
            r.frame_end = 1'b1;
            r.frame_status = ST_TIMEOUT;
            restart_hunt();
            return 1'b1;
        end
        if (rx_phase == P_HUNT)
        begin
            if (rx != cfg_start)
                return 1'b0;
            crc_acc = crc16_byte(CRC_INIT, rx);
            frame_pos = 9'd1;
            rx_phase = P_VERSION;
            r.frame_byte = rx;
            return 1'b1;
        end
        r.frame_byte = rx;
        r.byte_position = frame_pos;
        case (rx_phase)
            P_VERSION:
            begin
                version_byte = rx;
                crc_acc = crc16_byte(crc_acc, rx);
                rx_phase = P_LENGTH;
            end
            P_LENGTH:
            begin
                total = {1'b0, rx} + HDR_EXTRA;
                crc_acc = crc16_byte(crc_acc, rx);
                if (version_byte != cfg_version)
                begin
                    r.frame_end = 1'b1;
                    r.frame_status = ST_BAD_VERSION;
                end
                else if (total > MAX_TOTAL || total < MIN_TOTAL)
                begin
                    r.frame_end = 1'b1;
                    r.frame_status = ST_BAD_LENGTH;
                end
                else
                begin
                    frame_len_total = total;
                    rx_phase = P_BODY;
                end
            end
            default:
            begin
                if (frame_pos + 9'd3 < frame_len_total)
                    crc_acc = crc16_byte(crc_acc, rx);
                else if (frame_pos + 9'd3 == frame_len_total)
                    crc_rx_hi = rx;
                else if (frame_pos + 9'd2 == frame_len_total)
                    crc_ok = ({crc_rx_hi, rx} == crc_acc);
                else
                begin
                    r.frame_end = 1'b1;
                    if (rx != cfg_end)
                        r.frame_status = ST_BAD_END;
                    else if (!crc_ok)
                        r.frame_status = ST_CRC_ERR;
                    else
                        r.frame_status = ST_OK;
                end
            end
        endcase
        if (r.frame_end)
            restart_hunt();
        else
            frame_pos = frame_pos + 9'd1;
        return 1'b1;
    endfunction

    task automatic set_idle_mode(input int mode);
        case (mode)
            1: begin src_idle_pct = 69; snk_stall_pct = 0; end
            2: begin src_idle_pct = 0; snk_stall_pct = 69; end
            3: begin src_idle_pct = 6; snk_stall_pct = 6; end
            default: begin src_idle_pct = 0; snk_stall_pct = 0; end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_START_MARKER: cfg_start = val;
            REG_EXP_VERSION: cfg_version = val;
            REG_END_MARKER: cfg_end = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one item, wait for the handshake, then record its expectation
    task automatic send_item(input logic cmd, input logic [7:0] val, input byte_sel_t sel,
                             input bit typed, input bit has_res, input frame_result_t typed_res);
        logic [7:0] v;
        frame_result_t r;
        bit has;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        case (sel)
            SEL_CRC_HI: v = crc_acc[15:8];
            SEL_CRC_LO: v = crc_acc[7:0];
            SEL_CRC_BAD: v = crc_acc[7:0] ^ val;
            default: v = val;
        endcase
        item_ch.valid <= 1'b1;
        item_ch.command <= cmd;
        item_ch.rx_value <= v;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
        has = predict_frame_result(cmd, v, r);
        if (typed)
        begin
            has = has_res;
            r = typed_res;
        end
        if (has)
        begin
            expected_results.push_back(r);
            results_predicted++;
        end
    endtask

    task automatic offer(input logic cmd, input logic [7:0] val, input byte_sel_t sel);
        send_item(cmd, val, sel, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed frames with random payload, plus noise and broken frames
    task automatic play_random_sequence();
        int kind;
        int len;
        int cut;
        int noise;
        logic [7:0] ver;
        noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (noise) offer(CMD_BYTE, 8'($urandom_range(0, 255)), SEL_LIT);
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            offer(CMD_TIMEOUT, 8'($urandom_range(0, 255)), SEL_LIT);
            return;
        end
        case ($urandom_range(0, 9))
            7, 8: len = $urandom_range(3, MAX_DATA + 6);
            9: len = MAX_DATA + 6;
            default: len = $urandom_range(3, 10);
        endcase
        if (kind < 10)
            len = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(MAX_DATA + 7, 255);
        ver = (kind >= 10 && kind < 15) ? cfg_version ^ 8'($urandom_range(1, 255)) : cfg_version;
        offer(CMD_BYTE, cfg_start, SEL_LIT);
        offer(CMD_BYTE, ver, SEL_LIT);
        offer(CMD_BYTE, 8'(len), SEL_LIT);
        if (kind < 15)
            return;
        cut = (kind < 20) ? $urandom_range(3, len + 2) : -1;
        for (int p = 3; p <= len + 2; p++)
        begin
            if (p == cut)
            begin
                offer(CMD_TIMEOUT, 8'($urandom_range(0, 255)), SEL_LIT);
                return;
            end
            if (p < len)
                offer(CMD_BYTE, 8'($urandom_range(0, 255)), SEL_LIT);
            else if (p == len)
                offer(CMD_BYTE, 8'h00, SEL_CRC_HI);
            else if (p == len + 1)
            begin
                if (kind >= 20 && kind < 27)
                    offer(CMD_BYTE, 8'($urandom_range(1, 255)), SEL_CRC_BAD);
                else
                    offer(CMD_BYTE, 8'h00, SEL_CRC_LO);
            end
            else if (kind >= 27 && kind < 33)
                offer(CMD_BYTE, cfg_end ^ 8'($urandom_range(1, 255)), SEL_LIT);
            else
                offer(CMD_BYTE, cfg_end, SEL_LIT);
        end
    endtask

    initial
    begin : sink_side
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req != long_hold_ack)
            begin
                long_hold_ack = long_hold_req;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_checked++;
            if (result_ch.frame_end)
                status_seen[result_ch.frame_status]++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: byte %0h position %0d end %0b status %0d",
                       result_ch.frame_byte, result_ch.byte_position,
                       result_ch.frame_end, result_ch.frame_status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.frame_byte !== want.frame_byte)
                begin
                    $error("frame_byte: expected %0h, actual %0h",
                           want.frame_byte, result_ch.frame_byte);
                    errors++;
                end
                if (result_ch.byte_position !== want.byte_position)
                begin
                    $error("byte_position: expected %0d, actual %0d",
                           want.byte_position, result_ch.byte_position);
                    errors++;
                end
                if (result_ch.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, actual %0b",
                           want.frame_end, result_ch.frame_end);
                    errors++;
                end
                if (result_ch.frame_status !== want.frame_status)
                begin
                    $error("frame_status: expected %0d, actual %0d",
                           want.frame_status, result_ch.frame_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : run
        int round_base;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.command <= CMD_BYTE;
        item_ch.rx_value <= '0;
        cfg_start = 8'hAA;
        cfg_version = 8'h01;
        cfg_end = 8'h55;
        restart_hunt();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run on the reset values of the marker registers
        set_idle_mode(3);
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(directed_rows[i].command, directed_rows[i].rx_value, directed_rows[i].sel,
                      directed_rows[i].typed, directed_rows[i].has_result,
                      directed_rows[i].want);
        drain();

        for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++)
        begin
            case (rnd)
                0:
                begin
                    write_reg(REG_START_MARKER, 8'hAA);
                    write_reg(REG_EXP_VERSION, 8'h01);
                    write_reg(REG_END_MARKER, 8'h55);
                end
                1:
                begin
                    write_reg(REG_START_MARKER, 8'h00);
                    write_reg(REG_EXP_VERSION, 8'h00);
                    write_reg(REG_END_MARKER, 8'h00);
                end
                2:
                begin
                    write_reg(REG_START_MARKER, 8'hFF);
                    write_reg(REG_EXP_VERSION, 8'hFF);
                    write_reg(REG_END_MARKER, 8'hFF);
                end
                default:
                begin
                    write_reg(REG_START_MARKER, 8'($urandom_range(0, 255)));
                    write_reg(REG_EXP_VERSION, 8'($urandom_range(0, 255)));
                    write_reg(REG_END_MARKER, 8'($urandom_range(0, 255)));
                end
            endcase
            cfg_we <= 1'b0;
            settings_used++;
            set_idle_mode(rnd % 4);
            if (rnd == 0)
                long_hold_req = ~long_hold_req;
            round_base = results_predicted;
            while (results_predicted - round_base < RESULTS_PER_ROUND)
                play_random_sequence();
            // leave the parser hunting before the next register change
            offer(CMD_TIMEOUT, 8'($urandom_range(0, 255)), SEL_LIT);
            drain();
        end

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("Run: %0d items in, %0d results checked, %0d marker settings",
                 items_sent, results_checked, settings_used);
        $display("Frame ends: ok %0d, timeout %0d, version %0d, length %0d, end %0d, crc %0d",
                 status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_BAD_VERSION],
                 status_seen[ST_BAD_LENGTH], status_seen[ST_BAD_END], status_seen[ST_CRC_ERR]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
